// ----- sv/mmt_pkg.sv -----
// Package for the maximal munch tokenizer: kind codes, reserved word table,
// character classes and the per-character classification step.
// No dependencies.
`default_nettype none
package mmt_pkg;

  localparam int WORD_COUNT = 36;
  localparam int WORD_MAX = 8;

  localparam logic [2:0] KIND_RES     = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_INT     = 3'd2;
  localparam logic [2:0] KIND_WS      = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  typedef logic [WORD_COUNT-1:0] word_mask_t;

  // Reserved word text, 8 chars, first char in the low byte, zero padded
  function automatic logic [63:0] word_text(input logic [5:0] idx);
    logic [63:0] t;
    t = '0;
    case (idx)
      6'd0:  t = 64'h3b;
      6'd1:  t = 64'h3d3a;
      6'd2:  t = 64'h3d2b3a;
      6'd3:  t = 64'h3d2d3a;
      6'd4:  t = 64'h3d2a3a;
      6'd5:  t = 64'h3d2f3a;
      6'd6:  t = 64'h3d253a;
      6'd7:  t = 64'h2a;
      6'd8:  t = 64'h2f;
      6'd9:  t = 64'h25;
      6'd10: t = 64'h2b;
      6'd11: t = 64'h2d;
      6'd12: t = 64'h3d;
      6'd13: t = 64'h3c;
      6'd14: t = 64'h3e;
      6'd15: t = 64'h3d3c;
      6'd16: t = 64'h3d3e;
      6'd17: t = 64'h3d2f;
      6'd18: t = 64'h28;
      6'd19: t = 64'h29;
      6'd20: t = 64'h7b;
      6'd21: t = 64'h7d;
      6'd22: t = 64'h646e61;
      6'd23: t = 64'h726f;
      6'd24: t = 64'h746f6e;
      6'd25: t = 64'h726f78;
      6'd26: t = 64'h746e69;
      6'd27: t = 64'h666564;
      6'd28: t = 64'h726176;
      6'd29: t = 64'h6e7275746572;
      6'd30: t = 64'h6669;
      6'd31: t = 64'h65736c65;
      6'd32: t = 64'h656c696877;
      6'd33: t = 64'h726f66;
      6'd34: t = 64'h6b61657262;
      6'd35: t = 64'h65756e69746e6f63;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] word_len(input logic [5:0] idx);
    logic [3:0] l;
    logic [63:0] wt;
    l = '0;
    wt = word_text(idx);
    for (int b = 0; b < WORD_MAX; b++) begin
      if (wt[b*8 +: 8] != 8'd0) l = 4'(b + 1);
    end
    return l;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c == 8'h5f) || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  typedef struct packed {
    logic [2:0] kind;
    word_mask_t mask;
    logic       ident;
    logic       integ;
  } cls_t;

  // Classify pending text extended by c; pos is the stored length, pos_ok
  // says the text is short enough and not overflowed for word matching
  function automatic cls_t classify(input logic [7:0] c, input logic empty,
                                    input logic pos_ok, input logic [3:0] pos,
                                    input word_mask_t mask, input logic ident,
                                    input logic integ);
    cls_t r;
    logic full, nid, nint, nws;
    logic [3:0] wl;
    logic [63:0] wt;
    r = '0;
    full = 1'b0;
    for (int i = 0; i < WORD_COUNT; i++) begin
      wl = word_len(6'(i));
      wt = word_text(6'(i));
      if (pos_ok && mask[i] && pos < wl && wt[pos[2:0]*8 +: 8] == c) begin
        r.mask[i] = 1'b1;
        if (pos + 4'd1 == wl) full = 1'b1;
      end
    end
    nid = ident && (is_alpha(c) || (!empty && is_digit(c)));
    nint = (empty && c == 8'h30) ||
           (integ && (empty ? (c >= 8'h31 && c <= 8'h39) : is_digit(c)));
    nws = empty && (c == 8'h20 || c == 8'h0a);
    if (full) r.kind = KIND_RES;
    else if (nid) r.kind = KIND_IDENT;
    else if (nint) r.kind = KIND_INT;
    else if (nws) r.kind = KIND_WS;
    else r.kind = KIND_UNKNOWN;
    r.ident = nid;
    r.integ = nint && !(empty && c == 8'h30);
    return r;
  endfunction

  typedef struct packed {
    logic accept;   // take the input char
    logic append;   // append the held char to the pending text
    logic restart;  // restart pending text from the held char
    logic emit;     // advance the emit pointer
  } mmt_cmd_t;

  typedef struct packed {
    logic ends_token; // held char ends a known non-ws token
    logic drops_ws;   // held char ends a whitespace token
    logic last;       // emit pointer at final stored char
  } mmt_sts_t;

endpackage
`default_nettype wire

// ----- sv/mmt_datapath.sv -----
// Datapath of the tokenizer: pending token store, flags, line counter and
// emit pointer. Uses mmt_pkg; driven by mmt_ctrl commands.
`default_nettype none
module mmt_datapath import mmt_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int LINE_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  ch,
  input  wire mmt_cmd_t    cmd,
  output mmt_sts_t         sts,
  output logic [7:0]       tok_char,
  output logic [1:0]       tok_kind,
  output logic [23:0]      tok_line,
  output logic             truncated
);
  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int AW = $clog2(MAX_TOKEN_LEN);

  logic [7:0] store [MAX_TOKEN_LEN];
  logic [LW-1:0] token_len, emit_ptr;
  logic [2:0] pending_kind;
  word_mask_t reserved_mask;
  logic ident_flag, integer_flag, overflow_flag;
  logic [LINE_BITS-1:0] line_count;
  logic [7:0] held;
  logic [7:0] rd_data;
  logic wr_en;
  logic [AW-1:0] wr_addr;

  cls_t ext, fresh, upd;
  logic empty, ext_unknown;

  // classify held char against current and cleared pending text
  assign empty = (token_len == '0) && !overflow_flag;
  assign ext = classify(held, empty, !overflow_flag && token_len < LW'(9),
                        token_len[3:0], reserved_mask, ident_flag, integer_flag);
  assign fresh = classify(held, 1'b1, 1'b1, 4'd0, '1, 1'b1, 1'b1);
  assign ext_unknown = pending_kind != KIND_UNKNOWN && ext.kind == KIND_UNKNOWN;
  assign upd = cmd.restart ? fresh : ext;

  assign sts = '{ends_token: ext_unknown && pending_kind != KIND_WS,
                 drops_ws: ext_unknown && pending_kind == KIND_WS,
                 last: (emit_ptr + LW'(1)) == token_len};

  // store the held char at the tail, or at the head on restart
  assign wr_en = cmd.restart || (cmd.append && token_len < LW'(MAX_TOKEN_LEN));
  assign wr_addr = cmd.restart ? '0 : token_len[AW-1:0];

  // hold input char; write and read the token store
  always_ff @(posedge clk) begin
    if (cmd.accept) held <= ch;
    if (wr_en) store[wr_addr] <= held;
    rd_data <= store[emit_ptr[AW-1:0]];
  end

  // update pending state, line count and emit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      token_len <= '0;
      pending_kind <= KIND_UNKNOWN;
      reserved_mask <= '1;
      ident_flag <= 1'b1;
      integer_flag <= 1'b1;
      overflow_flag <= 1'b0;
      emit_ptr <= '0;
    end else begin
      if (cmd.accept && ch == 8'h0a) line_count <= line_count + 1'b1;
      if (cmd.append || cmd.restart) begin
        pending_kind <= upd.kind;
        reserved_mask <= upd.mask;
        ident_flag <= upd.ident;
        integer_flag <= upd.integ;
      end
      if (cmd.restart) begin
        token_len <= LW'(1);
        overflow_flag <= 1'b0;
      end else if (cmd.append) begin
        if (token_len < LW'(MAX_TOKEN_LEN)) token_len <= token_len + LW'(1);
        else overflow_flag <= 1'b1;
      end
      if (cmd.restart) emit_ptr <= '0;
      else if (cmd.emit) emit_ptr <= emit_ptr + LW'(1);
    end
  end

  // pending kind and overflow hold still until the restart after emission
  assign tok_char = rd_data;
  assign tok_kind = pending_kind[1:0];
  assign tok_line = 24'(line_count);
  assign truncated = overflow_flag;
endmodule
`default_nettype wire

// ----- sv/mmt_ctrl.sv -----
// Controller of the tokenizer: sequences accept, classify, emit, restart.
// Uses mmt_pkg; drives mmt_datapath.
`default_nettype none
module mmt_ctrl import mmt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output logic          last_char,
  input  wire mmt_sts_t sts,
  output mmt_cmd_t      cmd
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLASS = 5'b00010,
    S_READ  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_RST   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic last_reg;

  assign in_stall = state != S_IDLE;
  assign out_valid = state == S_EMIT;
  assign last_char = last_reg;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = S_CLASS;
      end
      S_CLASS: begin
        if (sts.ends_token) state_next = S_READ;
        else if (sts.drops_ws) state_next = S_RST;
        else begin
          cmd.append = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: state_next = S_EMIT;
      S_EMIT: begin
        if (!out_stall) begin
          cmd.emit = 1'b1;
          state_next = last_reg ? S_RST : S_READ;
        end
      end
      S_RST: begin
        cmd.restart = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
    if (state == S_READ) last_reg <= sts.last;
  end
endmodule
`default_nettype wire

// ----- sv/maximal_munch_tokenizer_unit.sv -----
// Maximal munch tokenizer: takes one byte per transfer and emits each
// finished token one character per transfer with its kind and line number.
// An input byte that does not end a token is accepted in S_IDLE and
// appended in S_CLASS; one that ends a token adds a store read and an
// output state (S_READ, S_EMIT) per emitted character plus a restart
// state (S_RST), set by the single read port of the token store. A byte that
// ends a whitespace token adds only S_RST; output stall holds S_EMIT.
`default_nettype none
module maximal_munch_tokenizer_unit import mmt_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int LINE_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  ch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       tok_char,
  output logic [1:0]       tok_kind,
  output logic [23:0]      tok_line,
  output logic             last_char,
  output logic             truncated
);
  mmt_cmd_t cmd;
  mmt_sts_t sts;

  mmt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .last_char, .sts, .cmd
  );

  mmt_datapath #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN), .LINE_BITS(LINE_BITS)) u_dp (
    .clk, .rst, .ch, .cmd, .sts, .tok_char, .tok_kind, .tok_line, .truncated
  );
endmodule
`default_nettype wire
